[sv/bst_pkg.sv]
// ----------------------------------------------------------------------------
// bst_pkg
// Shared constants and types for the beacon sighting merge table.
// ----------------------------------------------------------------------------
package bst_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int LEN_W  = 8;
    localparam int HDR_W  = 32;
    localparam int ADDR_W = 48;
    localparam int RSSI_W = 8;

    localparam int IN_DATA_W  = LEN_W + HDR_W + ADDR_W + RSSI_W;
    localparam int OUT_DATA_W = ADDR_W + RSSI_W;

    localparam logic [HDR_W-1:0] HDR_MATCH   = 32'h4C00_1219;
    localparam logic [LEN_W-1:0] MIN_MFR_LEN = 8'd4;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    typedef struct packed {
        logic report;
        logic start;
        logic emit;
        logic clear;
    } bst_cmd_t;

    typedef struct packed {
        logic out_free;
        logic at_last;
    } bst_status_t;

endpackage

[sv/bst_ctrl.sv]
// ----------------------------------------------------------------------------
// bst_ctrl
// Controller that accepts items and sequences the flush run.
// ----------------------------------------------------------------------------
module bst_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                kind,
    output logic                s_tready,
    input  bst_pkg::bst_status_t status,
    output bst_pkg::bst_cmd_t    cmd
);
    import bst_pkg::*;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_FLUSH = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && kind == KIND_REPORT)
                begin
                    cmd.report = 1'b1;
                end
                if (accept && kind == KIND_FLUSH)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.at_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/bst_datapath.sv]
// ----------------------------------------------------------------------------
// bst_datapath
// Entry storage, parallel address match, merge logic and output register.
// ----------------------------------------------------------------------------
module bst_datapath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  bst_pkg::bst_cmd_t           cmd,
    output bst_pkg::bst_status_t        status,
    input  logic [bst_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bst_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                        m_tuser,
    output logic                        m_tlast
);
    import bst_pkg::*;

    logic [LEN_W-1:0]  in_len;
    logic [HDR_W-1:0]  in_hdr;
    logic [ADDR_W-1:0] in_addr;
    logic [RSSI_W-1:0] in_rssi;

    logic [ADDR_W-1:0] addr_reg [TABLE_DEPTH];
    logic [RSSI_W-1:0] rssi_reg [TABLE_DEPTH];
    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  rd_idx_reg;

    logic              m_tvalid_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [RSSI_W-1:0] out_rssi_reg;
    logic              out_valid_reg;
    logic              out_last_reg;

    logic [TABLE_DEPTH-1:0] match_vec;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic              hdr_ok;
    logic              count_zero;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic              append;
    logic              stronger;

    assign in_len  = s_tdata[LEN_W-1:0];
    assign in_hdr  = s_tdata[LEN_W +: HDR_W];
    assign in_addr = s_tdata[LEN_W+HDR_W +: ADDR_W];
    assign in_rssi = s_tdata[LEN_W+HDR_W+ADDR_W +: RSSI_W];

    assign hdr_ok     = (in_len >= MIN_MFR_LEN) && (in_hdr == HDR_MATCH);
    assign count_zero = (count_reg == '0);

    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            match_vec[i] = (CNT_W'(i) < count_reg) && (addr_reg[i] == in_addr);
        end
    end

    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign stronger = $signed(in_rssi) > $signed(rssi_reg[hit_idx]);
    assign append   = cmd.report && hdr_ok && !hit && (count_reg < CNT_W'(TABLE_DEPTH));
    assign wr_en    = append || (cmd.report && hdr_ok && hit && stronger);
    assign wr_idx   = hit ? hit_idx : count_reg[IDX_W-1:0];

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign status.at_last  = count_zero || ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rssi_reg[wr_idx] <= in_rssi;
            if (append)
            begin
                addr_reg[wr_idx] <= in_addr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            rd_idx_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            else if (append)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end

            if (cmd.start)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.emit)
            begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
            end

            if (cmd.emit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_addr_reg  <= count_zero ? '0 : addr_reg[rd_idx_reg];
            out_rssi_reg  <= count_zero ? '0 : rssi_reg[rd_idx_reg];
            out_valid_reg <= !count_zero;
            out_last_reg  <= status.at_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_rssi_reg, out_addr_reg};
    assign m_tuser  = out_valid_reg;
    assign m_tlast  = out_last_reg;

endmodule

[sv/beacon_sighting_merge_table.sv]
// ----------------------------------------------------------------------------
// beacon_sighting_merge_table
// Collects matching advertisement reports per address and flushes them.
// ----------------------------------------------------------------------------
// Outside a flush run, reports can arrive every cycle; each report's address
// is compared against all held entries at once. A flush item stops
// the input until the last result of its run has been loaded into the output
// register. It emits one result for an empty window, otherwise one per held
// entry, up to 16, each waiting on the single output register to be taken
// downstream. The entry store needs no clearing pass after reset.
module beacon_sighting_merge_table
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // mfr_len, mfr_header, adv_address, adv_rssi
    input  logic [bst_pkg::IN_DATA_W-1:0]   s_tdata,
    // kind
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // entry_address, entry_rssi
    output logic [bst_pkg::OUT_DATA_W-1:0]  m_tdata,
    // entry_valid
    output logic                            m_tuser,
    output logic                            m_tlast
);
    import bst_pkg::*;

    bst_cmd_t    cmd;
    bst_status_t status;

    bst_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .kind     (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bst_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[sv/bst_checker.sv]
// ----------------------------------------------------------------------------
// bst_checker
// Port-level checks for the beacon sighting merge table.
// ----------------------------------------------------------------------------
module bst_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [bst_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic                            m_tuser,
    input logic                            m_tlast
);
    import bst_pkg::*;

    // A flush item holds off the input while its run is under way.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == KIND_FLUSH) |=> !s_tready)
        else $error("input taken right after a flush item");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

    // The empty-window marker is alone, zeroed and last.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tlast && m_tdata == '0))
        else $error("malformed empty-window marker");

    // While a run is still incomplete, no input item is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("input open in the middle of a flush run");

endmodule

bind beacon_sighting_merge_table bst_checker u_bst_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
